// ===== sv/pile_tail_placement_unit_assert.svh =====
// Assertion macros for the pile tail placement unit.
// Expects clk and rst_n in the scope of the module that uses them.
`ifndef PILE_TAIL_PLACEMENT_UNIT_ASSERT_SVH
`define PILE_TAIL_PLACEMENT_UNIT_ASSERT_SVH

// Property that must hold at every clock edge out of reset.
`define PTP_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("pile tail placement: invariant violated");

// Antecedent in this cycle implies consequent in the next one.
`define PTP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pile tail placement: sequencing violated");

`endif

// ===== sv/ptp_pkg.sv =====
// Shared constants for the pile tail placement unit.
// No dependencies.
package ptp_pkg;

  localparam int VALUE_W = 32;
  localparam int INDEX_W = 10;
  localparam int COUNT_W = 11;

  typedef logic signed [VALUE_W-1:0] value_t;

endpackage

// ===== sv/pile_tail_placement_unit.sv =====
// Pile tail placement unit: patience-sort pile placement over a tail memory.
// Depends on ptp_pkg and pile_tail_placement_unit_assert.svh.
//
// Usage:
//   Input: drive in_value and in_first_of_set with start high; the transaction
//   is taken at a clock edge where start is high and busy is low. With
//   in_first_of_set high the pile count is cleared before placement.
//   Output: out_strobe is high for exactly one cycle with out_pile_index,
//   out_new_pile, out_overflow and out_pile_count. The receiver cannot stall;
//   the result must be captured in that cycle.
//   Operation: the tails live in one synchronous RAM (MAX_PILES x 32 bits,
//   registered read). The binary search issues one RAM probe per cycle, so
//   with N piles in use it takes P probes, at most ceil(log2(N+1)), then the
//   write-back in the finish state. out_strobe is registered from the finish
//   state, busy is low again in the strobe cycle, and a new transaction can
//   be accepted in that cycle.
//   Reset: clears the pile count and control state; the tail RAM is not
//   cleared, only entries below the pile count are ever read.
`include "pile_tail_placement_unit_assert.svh"

module pile_tail_placement_unit #(
  parameter int MAX_PILES = 1024
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [ptp_pkg::VALUE_W-1:0] in_value,
  input  logic                              in_first_of_set,
  output logic                              out_strobe,
  output logic [ptp_pkg::INDEX_W-1:0]       out_pile_index,
  output logic                              out_new_pile,
  output logic                              out_overflow,
  output logic [ptp_pkg::COUNT_W-1:0]       out_pile_count
);

  localparam int AW = $clog2(MAX_PILES);
  localparam int CW = $clog2(MAX_PILES + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_PILES);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_FINISH
  } state_t;

  state_t                       state_r, state_nxt;
  ptp_pkg::value_t              val_r, val_nxt;
  logic [CW-1:0]                cnt_r, cnt_nxt;
  logic [CW-1:0]                lo_r, lo_nxt;
  logic [CW-1:0]                hi_r, hi_nxt;
  logic [AW-1:0]                mid_r, mid_nxt;
  logic                         out_strobe_r, out_strobe_nxt;
  logic [ptp_pkg::INDEX_W-1:0]  out_index_r, out_index_nxt;
  logic                         out_new_r, out_new_nxt;
  logic                         out_ovf_r, out_ovf_nxt;
  logic [ptp_pkg::COUNT_W-1:0]  out_count_r, out_count_nxt;

  // tail RAM
  ptp_pkg::value_t              tails_mem [MAX_PILES];
  ptp_pkg::value_t              rd_data_r;
  logic                         rd_en, wr_en;
  logic [AW-1:0]                wr_addr;

  logic                         accept;
  logic [CW-1:0]                cnt_eff;
  logic [CW-1:0]                lo_step, hi_step;
  logic                         tail_ge;

  function automatic logic [AW-1:0] mid_of(input logic [CW-1:0] lo, input logic [CW-1:0] hi);
    logic [CW:0] sum;
    sum = {1'b0, lo} + {1'b0, hi};
    return sum[AW:1];
  endfunction

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && (state_r == ST_IDLE);
  assign cnt_eff = in_first_of_set ? '0 : cnt_r;

  // rd_data_r holds tails[mid_r] while searching
  assign tail_ge = (rd_data_r >= val_r);
  assign lo_step = tail_ge ? lo_r : (CW'(mid_r) + CW'(1));
  assign hi_step = tail_ge ? CW'(mid_r) : hi_r;

  always_comb begin
    state_nxt      = state_r;
    val_nxt        = val_r;
    cnt_nxt        = cnt_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    mid_nxt        = mid_r;
    out_strobe_nxt = 1'b0;
    out_index_nxt  = out_index_r;
    out_new_nxt    = out_new_r;
    out_ovf_nxt    = out_ovf_r;
    out_count_nxt  = out_count_r;
    rd_en          = 1'b0;
    wr_en          = 1'b0;
    wr_addr        = lo_r[AW-1:0];
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          val_nxt = in_value;
          cnt_nxt = cnt_eff;
          lo_nxt  = '0;
          hi_nxt  = cnt_eff;
          mid_nxt = mid_of('0, cnt_eff);
          if (cnt_eff != '0) begin
            rd_en     = 1'b1;
            state_nxt = ST_SEARCH;
          end else begin
            state_nxt = ST_FINISH;
          end
        end
      end
      ST_SEARCH: begin
        lo_nxt  = lo_step;
        hi_nxt  = hi_step;
        mid_nxt = mid_of(lo_step, hi_step);
        if (lo_step < hi_step) begin
          rd_en = 1'b1;
        end else begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        out_strobe_nxt = 1'b1;
        out_new_nxt    = 1'b0;
        out_ovf_nxt    = 1'b0;
        out_index_nxt  = '0;
        if (lo_r < cnt_r) begin
          // replace an existing tail
          wr_en         = 1'b1;
          wr_addr       = lo_r[AW-1:0];
          out_index_nxt = ptp_pkg::INDEX_W'(lo_r);
        end else if (cnt_r < MAX_CNT) begin
          // open a new pile at the end
          wr_en         = 1'b1;
          wr_addr       = cnt_r[AW-1:0];
          out_index_nxt = ptp_pkg::INDEX_W'(cnt_r);
          out_new_nxt   = 1'b1;
          cnt_nxt       = cnt_r + CW'(1);
        end else begin
          out_ovf_nxt = 1'b1;
        end
        out_count_nxt = ptp_pkg::COUNT_W'(cnt_nxt);
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cnt_r        <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
    val_r       <= val_nxt;
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    mid_r       <= mid_nxt;
    out_index_r <= out_index_nxt;
    out_new_r   <= out_new_nxt;
    out_ovf_r   <= out_ovf_nxt;
    out_count_r <= out_count_nxt;
  end

  // single-port use: reads only on accept and while searching, writes only in finish
  always_ff @(posedge clk) begin
    if (wr_en) begin
      tails_mem[wr_addr] <= val_r;
    end
    if (rd_en) begin
      rd_data_r <= tails_mem[mid_nxt];
    end
  end

  assign out_strobe     = out_strobe_r;
  assign out_pile_index = out_index_r;
  assign out_new_pile   = out_new_r;
  assign out_overflow   = out_ovf_r;
  assign out_pile_count = out_count_r;

  `PTP_ASSERT_ALWAYS(a_cnt_bound, cnt_r <= MAX_CNT)
  `PTP_ASSERT_ALWAYS(a_search_window, (state_r != ST_SEARCH) || (lo_r < hi_r && hi_r <= cnt_r))
  `PTP_ASSERT_ALWAYS(a_strobe_idle, !out_strobe || !busy)
  `PTP_ASSERT_ALWAYS(a_flags_exclusive, !out_strobe || !(out_new_pile && out_overflow))
  `PTP_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !out_strobe)

endmodule
